>>> rtl/dltq_pkg.sv
// shared constants, types and codes for the delta-list timer queue
// no dependencies; imported by dltq_store and delta_list_timer_queue
package dltq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int DLY_W = 16;
   localparam int PID_W = 8;
   localparam int QC_W = 5;

   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_INSERT = 1'b1;

   localparam int RSP_EXPIRED_BIT = 0;
   localparam int RSP_INSERT_OK_BIT = 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_PLACE,
      ST_TICK
   } state_type;

   typedef enum logic [2:0] {
      SO_NONE,
      SO_INS_TAIL,
      SO_INS_MID,
      SO_REMOVE,
      SO_HEAD
   } store_op_type;

   typedef struct packed {
      store_op_type       op;
      logic [IDX_W-1:0]   pos;
      logic [DLY_W-1:0]   new_delay;
      logic [PID_W-1:0]   new_pid;
      logic [DLY_W-1:0]   fix_delay;
   } store_cmd_type;

endpackage

>>> rtl/dltq_store.sv
// entry store of the timer queue: a row of delay/process cells in list order
// depends on dltq_pkg; shifts up on insert, down on head removal
module dltq_store import dltq_pkg::*; (
   input  logic               clock,
   input  store_cmd_type      cmd,
   output logic [DLY_W-1:0]   rd_delay,
   output logic [DLY_W-1:0]   head_delay,
   output logic [PID_W-1:0]   head_pid
);

   logic [DLY_W-1:0] dly_ff [QUEUE_DEPTH];
   logic [PID_W-1:0] pid_ff [QUEUE_DEPTH];

   assign rd_delay   = dly_ff[cmd.pos];
   assign head_delay = dly_ff[0];
   assign head_pid   = pid_ff[0];

   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      logic [DLY_W-1:0] dly_prev;
      logic [PID_W-1:0] pid_prev;
      logic [DLY_W-1:0] dly_next;
      logic [PID_W-1:0] pid_next;
      logic [DLY_W-1:0] dly_in;
      logic [PID_W-1:0] pid_in;

      if (k == 0) begin : g_first
         assign dly_prev = '0;
         assign pid_prev = '0;
      end else begin : g_mid
         assign dly_prev = dly_ff[k-1];
         assign pid_prev = pid_ff[k-1];
      end

      if (k == QUEUE_DEPTH - 1) begin : g_last
         assign dly_next = '0;
         assign pid_next = '0;
      end else begin : g_body
         assign dly_next = dly_ff[k+1];
         assign pid_next = pid_ff[k+1];
      end

      always_comb begin
         dly_in = dly_ff[k];
         pid_in = pid_ff[k];
         case (cmd.op)
            SO_INS_TAIL, SO_INS_MID: begin
               if (IDX_W'(k) == cmd.pos) begin
                  dly_in = cmd.new_delay;
                  pid_in = cmd.new_pid;
               end else if (IDX_W'(k) > cmd.pos) begin
                  pid_in = pid_prev;
                  if (cmd.op == SO_INS_MID && IDX_W'(k - 1) == cmd.pos) begin
                     dly_in = cmd.fix_delay;
                  end else begin
                     dly_in = dly_prev;
                  end
               end
            end
            SO_REMOVE: begin
               dly_in = dly_next;
               pid_in = pid_next;
            end
            SO_HEAD: begin
               if (k == 0) begin
                  dly_in = cmd.new_delay;
               end
            end
            default: begin
            end
         endcase
      end

      always_ff @(posedge clock) begin
         dly_ff[k] <= dly_in;
         pid_ff[k] <= pid_in;
      end
   end

endmodule

>>> rtl/delta_list_timer_queue.sv
// delta-list timer queue top: sequencer around one shared subtractor
// depends on dltq_pkg and dltq_store
//
//  channel | dir | beat contents
//  req_    | in  | tuser: func; tdata: delay_seconds, process_id
//  rsp_    | out | tuser: expired_valid, insert_ok; tdata: expired_process, queue_count
//
// tick: ST_IDLE then ST_TICK; refused insert: ST_IDLE then ST_WALK
// insert that lands at list position p walks past p entries in ST_WALK, then goes
// through ST_PLACE mid-list, or writes straight from ST_WALK at the tail
// the walk steps through one entry per cycle on the single 17-bit subtractor
// reset: synchronous, empties the queue; entry contents stay undefined
// a new beat is taken while a result still waits in the output register
module delta_list_timer_queue import dltq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // delay_seconds[15:0], process_id[23:16]
   input  logic         req_tuser,   // func[0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // expired_process[7:0], queue_count[12:8], zero[15:13]
   output logic [1:0]   rsp_tuser    // expired_valid[0], insert_ok[1]
);

   state_type          state_ff, state_in;
   logic [DLY_W-1:0]   rest_ff, rest_in;
   logic [PID_W-1:0]   pid_ff, pid_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               exp_valid_ff, exp_valid_in;
   logic [PID_W-1:0]   exp_pid_ff, exp_pid_in;
   logic               ins_ok_ff, ins_ok_in;
   logic [QC_W-1:0]    qc_ff, qc_in;

   logic [DLY_W-1:0]   op_a, op_b;
   logic [DLY_W:0]     diff;
   logic               out_free, out_load, full, at_end;
   logic [CNT_W+QC_W-1:0] cnt_wide;
   store_cmd_type      cmd;
   logic [DLY_W-1:0]   rd_delay, head_delay;
   logic [PID_W-1:0]   head_pid;

   dltq_store u_store (
      .clock      (clock),
      .cmd        (cmd),
      .rd_delay   (rd_delay),
      .head_delay (head_delay),
      .head_pid   (head_pid)
   );

   assign diff     = {1'b0, op_a} - {1'b0, op_b};
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign full     = count_ff == CNT_W'(QUEUE_DEPTH);
   assign at_end   = CNT_W'(pos_ff) == count_ff;
   assign cnt_wide = {{QC_W{1'b0}}, count_in};

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, qc_ff, exp_pid_ff};
   assign rsp_tuser  = {ins_ok_ff, exp_valid_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_tuser == FUNC_INSERT) ? ST_WALK : ST_TICK;
            end
         end
         ST_WALK: begin
            if (full || at_end) begin
               if (out_free) state_in = ST_IDLE;
            end else if (diff[DLY_W]) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE, ST_TICK: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      rest_in       = rest_ff;
      pid_in        = pid_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      out_load      = 1'b0;
      exp_valid_in  = 1'b0;
      exp_pid_in    = '0;
      ins_ok_in     = 1'b0;
      op_a          = rest_ff;
      op_b          = rd_delay;
      cmd.op        = SO_NONE;
      cmd.pos       = pos_ff;
      cmd.new_delay = rest_ff;
      cmd.new_pid   = pid_ff;
      cmd.fix_delay = diff[DLY_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               rest_in = req_tdata[DLY_W-1:0];
               pid_in  = req_tdata[DLY_W +: PID_W];
               pos_in  = '0;
            end
         end
         ST_WALK: begin
            if (full) begin
               out_load = out_free;
            end else if (at_end) begin
               if (out_free) begin
                  cmd.op    = SO_INS_TAIL;
                  count_in  = count_ff + 1'b1;
                  out_load  = 1'b1;
                  ins_ok_in = 1'b1;
               end
            end else if (!diff[DLY_W]) begin
               rest_in = diff[DLY_W-1:0];
               pos_in  = pos_ff + 1'b1;
            end
         end
         ST_PLACE: begin
            op_a = rd_delay;
            op_b = rest_ff;
            if (out_free) begin
               cmd.op    = SO_INS_MID;
               count_in  = count_ff + 1'b1;
               out_load  = 1'b1;
               ins_ok_in = 1'b1;
            end
         end
         ST_TICK: begin
            op_a = head_delay;
            op_b = DLY_W'(1);
            if (out_free) begin
               out_load = 1'b1;
               if (count_ff != '0) begin
                  if (diff[DLY_W] || diff == '0) begin
                     cmd.op       = SO_REMOVE;
                     count_in     = count_ff - 1'b1;
                     exp_valid_in = 1'b1;
                     exp_pid_in   = head_pid;
                  end else begin
                     cmd.op        = SO_HEAD;
                     cmd.new_delay = diff[DLY_W-1:0];
                  end
               end
            end
         end
         default: begin
         end
      endcase
      qc_in        = cnt_wide[QC_W-1:0];
      rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff <= rest_in;
      pid_ff  <= pid_in;
      pos_ff  <= pos_in;
      if (out_load) begin
         exp_valid_ff <= exp_valid_in;
         exp_pid_ff   <= exp_pid_in;
         ins_ok_ff    <= ins_ok_in;
         qc_ff        <= qc_in;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count above queue depth");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      (!reset && state_ff == ST_IDLE) |=> count_ff == $past(count_ff))
      else $error("entry count moved while idle");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(exp_valid_ff && ins_ok_ff))
      else $error("result both expired and inserted");

   a_pid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !exp_valid_ff) |-> exp_pid_ff == '0)
      else $error("expired process set without expiry");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK || state_ff == ST_PLACE) |-> CNT_W'(pos_ff) <= count_ff)
      else $error("walk position past list end");
`endif

endmodule

>>> tb/delta_list_timer_queue_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for delta_list_timer_queue: directed table, then random ops
// depends on dltq_pkg and the delta_list_timer_queue rtl; predicts every response beat
module delta_list_timer_queue_tb import dltq_pkg::*; ();

   localparam int N_RANDOM = 1625;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;

   typedef struct packed {
      logic               woke;
      logic [PID_W-1:0]   woke_pid;
      logic               stored;
      logic [QC_W-1:0]    held;
   } step_status_type;

   typedef struct packed {
      logic               op;
      logic [DLY_W-1:0]   dly;
      logic [PID_W-1:0]   pid;
      logic               typed;
      step_status_type    want;
   } drill_row_type;

   // fields: op, delay, pid, typed, {woke, woke_pid, stored, held}
   localparam drill_row_type DRILL [25] = '{
      {FUNC_TICK,   16'h0000, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 5'd0},
      {FUNC_INSERT, 16'h0000, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b1, 5'd1},
      {FUNC_TICK,   16'h0000, 8'h00, 1'b1, 1'b1, 8'hFF, 1'b0, 5'd0},
      {FUNC_INSERT, 16'hFFFF, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1, 5'd1},
      {FUNC_INSERT, 16'd5,    8'h01, 1'b0, 15'd0},
      {FUNC_INSERT, 16'd5,    8'h02, 1'b0, 15'd0},
      {FUNC_INSERT, 16'd0,    8'h03, 1'b0, 15'd0},
      {FUNC_INSERT, 16'd3,    8'h04, 1'b0, 15'd0},
      {FUNC_INSERT, 16'd8,    8'h05, 1'b0, 15'd0},
      {FUNC_INSERT, 16'd1,    8'h06, 1'b0, 15'd0},
      {FUNC_INSERT, 16'd5,    8'h07, 1'b0, 15'd0},
      {FUNC_INSERT, 16'd0,    8'h08, 1'b0, 15'd0},
      {FUNC_INSERT, 16'd2,    8'h09, 1'b0, 15'd0},
      {FUNC_INSERT, 16'd12,   8'h0A, 1'b0, 15'd0},
      {FUNC_INSERT, 16'd7,    8'h0B, 1'b0, 15'd0},
      {FUNC_INSERT, 16'd4,    8'h0C, 1'b0, 15'd0},
      {FUNC_INSERT, 16'd6,    8'h0D, 1'b0, 15'd0},
      {FUNC_INSERT, 16'd9,    8'h0E, 1'b0, 15'd0},
      {FUNC_INSERT, 16'd1,    8'h0F, 1'b0, 15'd0},
      {FUNC_INSERT, 16'hFFFF, 8'hAA, 1'b1, 1'b0, 8'h00, 1'b0, 5'd16},
      {FUNC_INSERT, 16'h5A5A, 8'h55, 1'b1, 1'b0, 8'h00, 1'b0, 5'd16},
      {FUNC_TICK,   16'h0000, 8'h00, 1'b0, 15'd0},
      {FUNC_TICK,   16'h0000, 8'h00, 1'b0, 15'd0},
      {FUNC_TICK,   16'h0000, 8'h00, 1'b0, 15'd0},
      {FUNC_TICK,   16'hA5A5, 8'h3C, 1'b0, 15'd0}
   };

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [23:0]   req_tdata;   // delay_seconds[15:0], process_id[23:16]
   logic          req_tuser;   // func[0]
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [15:0]   rsp_tdata;   // expired_process[7:0], queue_count[12:8], zero[15:13]
   logic [1:0]    rsp_tuser;   // expired_valid[0], insert_ok[1]

   int               sleep_delay [QUEUE_DEPTH];
   logic [PID_W-1:0] sleep_pid [QUEUE_DEPTH];
   int               sleep_count;
   step_status_type  pending_status [$];
   int               mismatches;
   int               tx_idle_pct;
   int               rx_idle_pct;
   int               stall_cycles = 0;

   delta_list_timer_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic step_status_type apply_timer_op(input logic op,
                                                      input logic [DLY_W-1:0] dly,
                                                      input logic [PID_W-1:0] pid);
      step_status_type st;
      int rest;
      int pos;
      int k;
      st = '0;
      if (op == FUNC_INSERT) begin
         if (sleep_count < QUEUE_DEPTH) begin
            rest = int'(dly);
            pos = 0;
            while (pos < sleep_count && sleep_delay[pos] <= rest) begin
               rest -= sleep_delay[pos];
               pos++;
            end
            if (pos < sleep_count) sleep_delay[pos] -= rest;
            for (k = sleep_count; k > pos; k--) begin
               sleep_delay[k] = sleep_delay[k-1];
               sleep_pid[k] = sleep_pid[k-1];
            end
            sleep_delay[pos] = rest;
            sleep_pid[pos] = pid;
            sleep_count++;
            st.stored = 1'b1;
         end
      end else if (sleep_count > 0) begin
         sleep_delay[0] -= 1;
         if (sleep_delay[0] <= 0) begin
            st.woke = 1'b1;
            st.woke_pid = sleep_pid[0];
            for (k = 0; k + 1 < sleep_count; k++) begin
               sleep_delay[k] = sleep_delay[k+1];
               sleep_pid[k] = sleep_pid[k+1];
            end
            sleep_count--;
         end
      end
      st.held = QC_W'(sleep_count);
      return st;
   endfunction

   task automatic note_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   // drive one beat, wait for it to be taken, then queue its expected status (table row or predicted)
   task automatic issue_op(input logic op, input logic [DLY_W-1:0] dly,
                           input logic [PID_W-1:0] pid, input logic typed,
                           input step_status_type want);
      step_status_type predicted;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {pid, dly};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_timer_op(op, dly, pid);
      pending_status.push_back(typed ? want : predicted);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      step_status_type exp_st;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_status.size() == 0) begin
            note_mismatch($sformatf("response beat with nothing pending: tuser=%b tdata=%h",
                                    rsp_tuser, rsp_tdata));
         end else begin
            exp_st = pending_status.pop_front();
            if (rsp_tuser[RSP_EXPIRED_BIT] !== exp_st.woke)
               note_mismatch($sformatf("expired_valid %b, want %b",
                                       rsp_tuser[RSP_EXPIRED_BIT], exp_st.woke));
            if (rsp_tdata[7:0] !== exp_st.woke_pid)
               note_mismatch($sformatf("expired_process %h, want %h",
                                       rsp_tdata[7:0], exp_st.woke_pid));
            if (rsp_tuser[RSP_INSERT_OK_BIT] !== exp_st.stored)
               note_mismatch($sformatf("insert_ok %b, want %b",
                                       rsp_tuser[RSP_INSERT_OK_BIT], exp_st.stored));
            if (rsp_tdata[12:8] !== exp_st.held)
               note_mismatch($sformatf("queue_count %0d, want %0d",
                                       rsp_tdata[12:8], exp_st.held));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t watchdog: no beat for %0d cycles", $realtime, STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int i;
      int ins_pct;
      logic op;
      logic [DLY_W-1:0] dly;
      logic [PID_W-1:0] pid;
      mismatches = 0;
      sleep_count = 0;
      tx_idle_pct = 21;
      rx_idle_pct = 49;
      ins_pct = 50;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= FUNC_TICK;
      req_tdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DRILL[r])
         issue_op(DRILL[r].op, DRILL[r].dly, DRILL[r].pid, DRILL[r].typed, DRILL[r].want);

      for (i = 0; i < N_RANDOM; i++) begin
         case (i * 3 / N_RANDOM)
            0: begin
               tx_idle_pct = 21;
               rx_idle_pct = 49;
            end
            1: begin
               tx_idle_pct = 49;
               rx_idle_pct = 21;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         // swing the insert share so the list fills up and drains again
         if (i % 64 == 0) ins_pct = $urandom_range(25, 75);
         pid = PID_W'($urandom_range(0, 255));
         if (sleep_count == QUEUE_DEPTH && $urandom_range(0, 2) == 0) begin
            // full list: wide delays get refused and never park in a slot
            op = FUNC_INSERT;
            dly = DLY_W'($urandom_range(0, 65535));
         end else if ($urandom_range(0, 99) < ins_pct) begin
            op = FUNC_INSERT;
            dly = ($urandom_range(0, 15) == 0) ? 16'd0 : DLY_W'($urandom_range(1, 10));
         end else begin
            op = FUNC_TICK;
            dly = DLY_W'($urandom_range(0, 65535));
         end
         issue_op(op, dly, pid, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
